### rtl/round_robin_buffer_pool_macros.svh
// assertion macros for the buffer pool checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ROUND_ROBIN_BUFFER_POOL_MACROS_SVH
`define ROUND_ROBIN_BUFFER_POOL_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RRBP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buffer pool assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define RRBP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buffer pool assertion failed");

`endif

### rtl/rrbp_pkg.sv
// shared types and codes of the round robin buffer pool
// no dependencies; imported by the pool and its checker
`timescale 1ns / 1ps

package rrbp_pkg;

   // request modes
   localparam logic [2:0] MODE_ANNOUNCE = 3'd0;
   localparam logic [2:0] MODE_REVOKE   = 3'd1;
   localparam logic [2:0] MODE_QUEUE    = 3'd2;
   localparam logic [2:0] MODE_START    = 3'd3;
   localparam logic [2:0] MODE_STOP     = 3'd4;
   localparam logic [2:0] MODE_COMPLETE = 3'd5;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_NOTHING   = 2'd3;

   // fewest entries that allow a start
   localparam int MIN_START_ENTRIES = 2;

   localparam logic [31:0] PAYLOAD_SIZE_RESET = 32'd4096;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] buffer_key;
      logic [47:0] memory_addr;
      logic [31:0] buffer_size;
      logic [31:0] user_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        completed;
      logic [15:0] done_key;
      logic [47:0] done_addr;
      logic [31:0] done_tag;
      logic [63:0] batch_num;
      logic [31:0] fill_bytes;
   } rsp_type;

   // one stored buffer entry
   typedef struct packed {
      logic [15:0] key;
      logic [47:0] addr;
      logic [31:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### rtl/round_robin_buffer_pool.sv
// round robin buffer pool: entry table in ram, queued flags and counters in flops
// depends on rrbp_pkg and rrbp_ram
// announce, start and stop are decided in idle; queue and revoke read one entry per cycle in
// the search, then revoke closes the gap; complete reduces the pointer, scans the flags and
// reads the entry. one word at a time; the next request is taken the cycle after the result
// loads. reset: synchronous, clears count, pointer, batch, run flag, queued flags.
`timescale 1ns / 1ps

module round_robin_buffer_pool #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrbp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);

   import rrbp_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_CDATA = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [63:0]            batch_ff, batch_in;
   logic                   running_ff, running_in;
   logic [MAX_ENTRIES-1:0] queued_ff, queued_in;
   logic [31:0]            payload_ff;
   logic [2:0]             op_ff, op_in;
   logic [15:0]            key_ff, key_in;
   logic [CW-1:0]          walk_ff, walk_in;
   logic                   pend_ff, pend_in;
   logic [IW-1:0]          cmp_ff, cmp_in;
   logic [IW-1:0]          wdst_ff, wdst_in;
   logic [IW-1:0]          mod_ff, mod_in;
   logic [IW-1:0]          scan_ff, scan_in;
   logic [CW-1:0]          steps_ff, steps_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   ram_we;
   logic [IW-1:0]          ram_waddr;
   entry_type              ram_wdata;
   logic [IW-1:0]          ram_raddr;
   entry_type              ram_rdata;
   logic [ENTRY_W-1:0]     ram_rdata_raw;
   logic [MAX_ENTRIES-1:0] qshift;

   // entry table
   rrbp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_ENTRIES)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata_raw)
   );

   assign ram_rdata = entry_type'(ram_rdata_raw);
   assign qshift    = {1'b0, queued_ff[MAX_ENTRIES-1:1]};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // request sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      batch_in     = batch_ff;
      running_in   = running_ff;
      queued_in    = queued_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      cmp_in       = cmp_ff;
      wdst_in      = wdst_ff;
      mod_in       = mod_ff;
      scan_in      = scan_ff;
      steps_in     = steps_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in        = '0;
               res_in.status = ST_INVALID;
               op_in         = req_data.mode;
               key_in        = req_data.buffer_key;
               walk_in       = '0;
               pend_in       = 1'b0;
               state_in      = S_FIN;
               case (req_data.mode)
                  MODE_ANNOUNCE: begin
                     if (req_data.memory_addr != 48'd0 &&
                         req_data.buffer_size >= payload_ff &&
                         count_ff < CW'(MAX_ENTRIES)) begin
                        ram_we                       = 1'b1;
                        ram_waddr                    = count_ff[IW-1:0];
                        ram_wdata.key                = req_data.buffer_key;
                        ram_wdata.addr               = req_data.memory_addr;
                        ram_wdata.tag                = req_data.user_tag;
                        queued_in[count_ff[IW-1:0]]  = 1'b0;
                        count_in                     = count_ff + 1'b1;
                        res_in.status                = ST_OK;
                     end
                  end
                  MODE_REVOKE: begin
                     if (!running_ff) begin
                        if (count_ff == '0) begin
                           res_in.status = ST_NOT_FOUND;
                        end else begin
                           state_in = S_SRCH;
                        end
                     end
                  end
                  MODE_QUEUE: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_NOT_FOUND;
                     end else begin
                        state_in = S_SRCH;
                     end
                  end
                  MODE_START: begin
                     if (count_ff >= CW'(MIN_START_ENTRIES)) begin
                        batch_in      = '0;
                        running_in    = 1'b1;
                        res_in.status = ST_OK;
                     end
                  end
                  MODE_STOP: begin
                     queued_in     = '0;
                     running_in    = 1'b0;
                     res_in.status = ST_OK;
                  end
                  MODE_COMPLETE: begin
                     if (running_ff) begin
                        if (count_ff == '0) begin
                           res_in.status = ST_NOTHING;
                        end else begin
                           mod_in   = ptr_ff;
                           state_in = S_MOD;
                        end
                     end
                  end
                  default: begin
                     res_in.status = ST_INVALID;
                  end
               endcase
            end
         end

         // key lookup, one ram read issued and one compare per cycle
         S_SRCH: begin
            if (walk_ff < count_ff) begin
               ram_raddr = walk_ff[IW-1:0];
               pend_in   = 1'b1;
               cmp_in    = walk_ff[IW-1:0];
               walk_in   = walk_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (ram_rdata.key == key_ff) begin
                  state_in = S_FIN;
                  pend_in  = 1'b0;
                  if (op_ff == MODE_REVOKE) begin
                     res_in.status = ST_OK;
                     for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (IW'(j) >= cmp_ff) begin
                           queued_in[j] = qshift[j];
                        end
                     end
                     if (CW'(cmp_ff) + 1'b1 < count_ff) begin
                        walk_in  = CW'(cmp_ff) + 1'b1;
                        wdst_in  = cmp_ff;
                        state_in = S_SHIFT;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end else if (queued_ff[cmp_ff]) begin
                     res_in.status = ST_INVALID;
                  end else begin
                     queued_in[cmp_ff] = 1'b1;
                     res_in.status     = ST_OK;
                  end
               end else if (CW'(cmp_ff) + 1'b1 == count_ff) begin
                  res_in.status = ST_NOT_FOUND;
                  pend_in       = 1'b0;
                  state_in      = S_FIN;
               end
            end
         end

         // close the gap: read entry i+1, write it to i on the next cycle
         S_SHIFT: begin
            if (walk_ff < count_ff) begin
               ram_raddr = walk_ff[IW-1:0];
               pend_in   = 1'b1;
               walk_in   = walk_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wdst_ff;
               ram_wdata = ram_rdata;
               wdst_in   = wdst_ff + 1'b1;
               if (CW'(wdst_ff) + 2'd2 == count_ff) begin
                  count_in = count_ff - 1'b1;
                  pend_in  = 1'b0;
                  state_in = S_FIN;
               end
            end
         end

         // scan pointer modulo entry count by repeated subtraction
         S_MOD: begin
            if (CW'(mod_ff) >= count_ff) begin
               mod_in = mod_ff - count_ff[IW-1:0];
            end else begin
               scan_in  = mod_ff;
               steps_in = '0;
               state_in = S_SCAN;
            end
         end

         // round robin walk over the queued flags
         S_SCAN: begin
            if (queued_ff[scan_ff]) begin
               queued_in[scan_ff] = 1'b0;
               if (CW'(scan_ff) + 1'b1 == count_ff) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = scan_ff + 1'b1;
               end
               batch_in          = batch_ff + 64'd1;
               ram_raddr         = scan_ff;
               res_in.status     = ST_OK;
               res_in.completed  = 1'b1;
               res_in.batch_num  = batch_ff + 64'd1;
               res_in.fill_bytes = payload_ff;
               state_in          = S_CDATA;
            end else if (steps_ff + 1'b1 == count_ff) begin
               res_in.status = ST_NOTHING;
               state_in      = S_FIN;
            end else begin
               steps_in = steps_ff + 1'b1;
               if (CW'(scan_ff) + 1'b1 == count_ff) begin
                  scan_in = '0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end

         // pick up the completed entry from the ram
         S_CDATA: begin
            res_in.done_key  = ram_rdata.key;
            res_in.done_addr = ram_rdata.addr;
            res_in.done_tag  = ram_rdata.tag;
            state_in         = S_FIN;
         end

         // hand the result to the output register once it is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         batch_ff     <= '0;
         running_ff   <= 1'b0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         batch_ff     <= batch_in;
         running_ff   <= running_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // payload size register
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff <= PAYLOAD_SIZE_RESET;
      end else if (csr_we) begin
         payload_ff <= csr_wdata;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      walk_ff  <= walk_in;
      cmp_ff   <= cmp_in;
      wdst_ff  <= wdst_in;
      mod_ff   <= mod_in;
      scan_ff  <= scan_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### rtl/rrbp_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module rrbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rrbp_checker.sv
// port level checker for the round robin buffer pool, bound to the top level
// depends on rrbp_pkg and round_robin_buffer_pool_macros.svh
`timescale 1ns / 1ps
`include "round_robin_buffer_pool_macros.svh"

module rrbp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input rrbp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rrbp_pkg::rsp_type rsp_data
);

   import rrbp_pkg::*;

   logic req_taken;
   logic no_buffer;
   logic empty_fields;

   assign req_taken    = req_valid && req_ready && (req_data.mode == req_data.mode);
   assign no_buffer    = rsp_valid && !rsp_data.completed;
   assign empty_fields = rsp_data.done_key == 16'd0 && rsp_data.done_addr == 48'd0 &&
                         rsp_data.done_tag == 32'd0 && rsp_data.batch_num == 64'd0 &&
                         rsp_data.fill_bytes == 32'd0;

   // a stalled result word holds
   `RRBP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // one word at a time: no new request right after one is taken
   `RRBP_ASSERT_NXT(a_one_at_a_time, clock, reset, req_taken, !req_ready)

   // a returned buffer always comes with status ok
   `RRBP_ASSERT_IMP(a_completed_ok, clock, reset, rsp_valid && rsp_data.completed, rsp_data.status == ST_OK)

   // without a returned buffer the entry fields read zero
   `RRBP_ASSERT_IMP(a_empty_fields, clock, reset, no_buffer, empty_fields)

endmodule

bind round_robin_buffer_pool rrbp_checker u_rrbp_checker (.*);
